@@ rtl/core/frm_pkg.sv @@
// Shared types, constants and helpers for the fieldbus request framer.
// Used by frm_front, frm_queue, frm_back and fieldbus_request_framer_top.
// No dependencies.
package frm_pkg;

	// request kinds
	localparam logic [2:0] KIND_RD_COILS  = 3'd0;
	localparam logic [2:0] KIND_RD_INPUTS = 3'd1;
	localparam logic [2:0] KIND_RD_HOLD   = 3'd2;
	localparam logic [2:0] KIND_WR_SINGLE = 3'd3;
	localparam logic [2:0] KIND_WR_COILS  = 3'd4;
	localparam logic [2:0] KIND_WR_REGS   = 3'd5;

	// quantity limits
	localparam logic [15:0] COIL_READ_MAX  = 16'd2000;
	localparam logic [15:0] HOLD_READ_MAX  = 16'd125;
	localparam logic [15:0] COIL_WRITE_MAX = 16'd1968;
	localparam logic [15:0] REG_WRITE_MAX  = 16'd123;

	// result status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_QTY    = 2'd1;
	localparam logic [1:0] ST_ORPHAN = 2'd2;

	// configuration register indexes
	localparam logic CFG_UNIT_ID  = 1'b0;
	localparam logic CFG_TCP_MODE = 1'b1;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// byte positions within a header frame (RTU starts at the unit id)
	localparam logic [3:0] P_TXN_HI  = 4'd0;
	localparam logic [3:0] P_TXN_LO  = 4'd1;
	localparam logic [3:0] P_PROT_HI = 4'd2;
	localparam logic [3:0] P_PROT_LO = 4'd3;
	localparam logic [3:0] P_LEN_HI  = 4'd4;
	localparam logic [3:0] P_LEN_LO  = 4'd5;
	localparam logic [3:0] P_UNIT    = 4'd6;
	localparam logic [3:0] P_FCODE   = 4'd7;
	localparam logic [3:0] P_ADDR_HI = 4'd8;
	localparam logic [3:0] P_ADDR_LO = 4'd9;
	localparam logic [3:0] P_CV_HI   = 4'd10;
	localparam logic [3:0] P_CV_LO   = 4'd11;
	localparam logic [3:0] P_BCNT    = 4'd12;
	localparam logic [3:0] P_CRC_LO  = 4'd13;
	localparam logic [3:0] P_CRC_HI  = 4'd14;

	// byte positions within a payload element
	localparam logic [3:0] Q_DATA_HI = 4'd0;
	localparam logic [3:0] Q_DATA_LO = 4'd1;
	localparam logic [3:0] Q_CRC_LO  = 4'd2;
	localparam logic [3:0] Q_CRC_HI  = 4'd3;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef enum logic [1:0] {
		D_HDR,
		D_PAY,
		D_ERR_QTY,
		D_ERR_ORPHAN
	} dkind_t;

	// one classified item on its way from front to back
	typedef struct packed {
		dkind_t      dkind;
		logic [2:0]  kind;
		logic [15:0] addr;
		logic [15:0] cv;
		logic [15:0] pv;
		logic        tcp;
		logic [7:0]  unit;
		logic [15:0] txn;
		logic [7:0]  bcnt;
		logic        last;
	} desc_t;

	function automatic logic [7:0] fcode_of(input logic [2:0] kind);
		logic [7:0] f;
		case (kind)
			KIND_RD_COILS:  f = 8'd1;
			KIND_RD_INPUTS: f = 8'd2;
			KIND_RD_HOLD:   f = 8'd3;
			KIND_WR_SINGLE: f = 8'd6;
			KIND_WR_COILS:  f = 8'd15;
			KIND_WR_REGS:   f = 8'd16;
			default:        f = 8'd0;
		endcase
		return f;
	endfunction

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

@@ rtl/core/fieldbus_request_framer_top.sv @@
// Top level of the fieldbus request framer: configuration registers and the
// front, queue and back ends. Depends on frm_pkg, frm_front, frm_queue, frm_back.
// Throughput: one frame byte per cycle from the back end unless the receiver stalls;
// a header is 7 to 13 bytes, a payload element 1 to 4, an error result one beat; the
// front end takes one item per cycle until the four-entry descriptor queue fills.
// Reset: registers cleared, transaction counter zero, CRC 0xFFFF, descriptor queue and result empty.
module fieldbus_request_framer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        push,
	output logic        full,
	input  logic        action,
	input  logic [2:0]  request_kind,
	input  logic [15:0] start_address,
	input  logic [15:0] count_or_value,
	input  logic [15:0] payload_value,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  frame_byte,
	output logic        last_of_frame,
	output logic [1:0]  status
);

	logic [7:0]     unit_id_q;
	logic           tcp_mode_q;
	logic           accept;
	frm_pkg::desc_t f_desc;
	frm_pkg::desc_t q_desc;
	logic           q_valid;
	logic           q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_id_q  <= '0;
			tcp_mode_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				frm_pkg::CFG_UNIT_ID:  unit_id_q  <= cfg_data;
				frm_pkg::CFG_TCP_MODE: tcp_mode_q <= cfg_data[0];
				default:               unit_id_q  <= unit_id_q;
			endcase
		end
	end

	assign accept = push && !full;

	frm_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.action         (action),
		.request_kind   (request_kind),
		.start_address  (start_address),
		.count_or_value (count_or_value),
		.payload_value  (payload_value),
		.unit_id        (unit_id_q),
		.tcp_mode       (tcp_mode_q),
		.desc           (f_desc)
	);

	frm_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (accept),
		.wr_desc (f_desc),
		.full    (full),
		.rd      (q_pop),
		.valid   (q_valid),
		.rd_desc (q_desc)
	);

	frm_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_desc        (q_desc),
		.q_pop         (q_pop),
		.empty         (empty),
		.pop           (pop),
		.frame_byte    (frame_byte),
		.last_of_frame (last_of_frame),
		.status        (status)
	);

endmodule

@@ rtl/core/frm_front.sv @@
// Front end: accepts items, checks quantities and classifies each into a descriptor.
// Holds the transaction counter and pending payload state. Depends on frm_pkg.
module frm_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic                action,
	input  logic [2:0]          request_kind,
	input  logic [15:0]         start_address,
	input  logic [15:0]         count_or_value,
	input  logic [15:0]         payload_value,
	input  logic [7:0]          unit_id,
	input  logic                tcp_mode,
	output frm_pkg::desc_t      desc
);

	logic [15:0] txn_q;
	logic [7:0]  rem_q;
	logic [2:0]  pend_q;

	logic        pay_mode;
	logic        qty_ok;
	logic        multi;
	logic [16:0] coil_sum;
	logic [7:0]  bcnt;

	assign pay_mode = (rem_q != 8'd0);
	assign multi    = (request_kind == frm_pkg::KIND_WR_COILS) ||
		(request_kind == frm_pkg::KIND_WR_REGS);
	assign coil_sum = {1'b0, count_or_value} + 17'd7;

	always_comb begin
		case (request_kind)
			frm_pkg::KIND_RD_COILS, frm_pkg::KIND_RD_INPUTS:
				qty_ok = (count_or_value != 16'd0) && (count_or_value <= frm_pkg::COIL_READ_MAX);
			frm_pkg::KIND_RD_HOLD:
				qty_ok = (count_or_value != 16'd0) && (count_or_value <= frm_pkg::HOLD_READ_MAX);
			frm_pkg::KIND_WR_SINGLE:
				qty_ok = 1'b1;
			frm_pkg::KIND_WR_COILS:
				qty_ok = (count_or_value != 16'd0) && (count_or_value <= frm_pkg::COIL_WRITE_MAX);
			frm_pkg::KIND_WR_REGS:
				qty_ok = (count_or_value != 16'd0) && (count_or_value <= frm_pkg::REG_WRITE_MAX);
			default:
				qty_ok = 1'b0;
		endcase
	end

	// byte count fits in 8 bits once the quantity passed its limit
	always_comb begin
		case (request_kind)
			frm_pkg::KIND_WR_COILS: bcnt = coil_sum[10:3];
			frm_pkg::KIND_WR_REGS:  bcnt = {count_or_value[6:0], 1'b0};
			default:                bcnt = 8'd0;
		endcase
	end

	always_comb begin
		desc       = '0;
		desc.kind  = request_kind;
		desc.addr  = start_address;
		desc.cv    = count_or_value;
		desc.pv    = payload_value;
		desc.tcp   = tcp_mode;
		desc.unit  = unit_id;
		desc.txn   = txn_q + 16'd1;
		desc.bcnt  = bcnt;
		desc.last  = 1'b0;
		if (pay_mode) begin
			desc.dkind = frm_pkg::D_PAY;
			desc.kind  = pend_q;
			desc.last  = (rem_q == 8'd1);
		end else if (action) begin
			desc.dkind = frm_pkg::D_ERR_ORPHAN;
		end else if (!qty_ok) begin
			desc.dkind = frm_pkg::D_ERR_QTY;
		end else begin
			desc.dkind = frm_pkg::D_HDR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			txn_q  <= '0;
			rem_q  <= '0;
			pend_q <= '0;
		end else if (accept) begin
			if (pay_mode) begin
				rem_q <= rem_q - 8'd1;
			end else if (!action && qty_ok) begin
				if (tcp_mode) begin
					txn_q <= txn_q + 16'd1;
				end
				if (multi) begin
					rem_q  <= (request_kind == frm_pkg::KIND_WR_COILS) ? bcnt
						: count_or_value[7:0];
					pend_q <= request_kind;
				end
			end
		end
	end

endmodule

@@ rtl/core/frm_queue.sv @@
// Short descriptor queue between the front and back ends.
// Depends on frm_pkg for the descriptor type and depth.
module frm_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  frm_pkg::desc_t wr_desc,
	output logic           full,
	input  logic           rd,
	output logic           valid,
	output frm_pkg::desc_t rd_desc
);

	localparam int CNT_W = $clog2(frm_pkg::QUEUE_DEPTH + 1);

	frm_pkg::desc_t             mem_q [frm_pkg::QUEUE_DEPTH];
	logic [frm_pkg::QPTR_W-1:0] wptr_q;
	logic [frm_pkg::QPTR_W-1:0] rptr_q;
	logic [CNT_W-1:0]           cnt_q;

	assign full    = (cnt_q == CNT_W'(frm_pkg::QUEUE_DEPTH));
	assign valid   = (cnt_q != '0);
	assign rd_desc = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wptr_q] <= wr_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (rd) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/core/frm_back.sv @@
// Back end: expands each descriptor into frame bytes, one per cycle unless the output
// stalls, and runs the CRC. Drives the result register. Depends on frm_pkg.
module frm_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  frm_pkg::desc_t q_desc,
	output logic           q_pop,
	output logic           empty,
	input  logic           pop,
	output logic [7:0]     frame_byte,
	output logic           last_of_frame,
	output logic [1:0]     status
);

	logic [3:0]  pos_q;
	logic        first_q;
	logic [15:0] crc_q;
	logic        out_valid_q;
	logic [7:0]  byte_q;
	logic        last_q;
	logic [1:0]  status_q;

	logic        adv;
	logic        is_hdr;
	logic        multi;
	logic        rtu;
	logic [3:0]  pos;
	logic [3:0]  start_pos;
	logic [3:0]  next_pos;
	logic [7:0]  len_lo;
	logic [7:0]  b;
	logic [1:0]  st;
	logic        done;
	logic        feed;
	logic [15:0] crc_base;

	assign is_hdr = (q_desc.dkind == frm_pkg::D_HDR);
	assign multi  = (q_desc.kind == frm_pkg::KIND_WR_COILS) ||
		(q_desc.kind == frm_pkg::KIND_WR_REGS);
	assign rtu    = !q_desc.tcp;
	assign len_lo = multi ? (8'd7 + q_desc.bcnt) : 8'd6;

	always_comb begin
		if (is_hdr) begin
			start_pos = rtu ? frm_pkg::P_UNIT : frm_pkg::P_TXN_HI;
		end else if (q_desc.kind == frm_pkg::KIND_WR_COILS) begin
			start_pos = frm_pkg::Q_DATA_LO;
		end else begin
			start_pos = frm_pkg::Q_DATA_HI;
		end
	end

	assign pos = first_q ? start_pos : pos_q;

	always_comb begin
		b        = 8'd0;
		st       = frm_pkg::ST_OK;
		done     = 1'b0;
		feed     = 1'b0;
		next_pos = pos + 4'd1;
		case (q_desc.dkind)
			frm_pkg::D_HDR: begin
				feed = rtu && (pos <= frm_pkg::P_BCNT);
				case (pos)
					frm_pkg::P_TXN_HI:  b = q_desc.txn[15:8];
					frm_pkg::P_TXN_LO:  b = q_desc.txn[7:0];
					frm_pkg::P_PROT_HI: b = 8'd0;
					frm_pkg::P_PROT_LO: b = 8'd0;
					frm_pkg::P_LEN_HI:  b = 8'd0;
					frm_pkg::P_LEN_LO:  b = len_lo;
					frm_pkg::P_UNIT:    b = q_desc.unit;
					frm_pkg::P_FCODE:   b = frm_pkg::fcode_of(q_desc.kind);
					frm_pkg::P_ADDR_HI: b = q_desc.addr[15:8];
					frm_pkg::P_ADDR_LO: b = q_desc.addr[7:0];
					frm_pkg::P_CV_HI:   b = q_desc.cv[15:8];
					frm_pkg::P_CV_LO: begin
						b = q_desc.cv[7:0];
						// single requests skip the byte count
						if (!multi) begin
							next_pos = frm_pkg::P_CRC_LO;
							done     = !rtu;
						end
					end
					frm_pkg::P_BCNT: begin
						b    = q_desc.bcnt;
						done = 1'b1;
					end
					frm_pkg::P_CRC_LO:  b = crc_q[7:0];
					frm_pkg::P_CRC_HI: begin
						b    = crc_q[15:8];
						done = 1'b1;
					end
					default:            b = 8'd0;
				endcase
			end
			frm_pkg::D_PAY: begin
				feed = rtu && (pos <= frm_pkg::Q_DATA_LO);
				case (pos)
					frm_pkg::Q_DATA_HI: b = q_desc.pv[15:8];
					frm_pkg::Q_DATA_LO: begin
						b    = q_desc.pv[7:0];
						done = !q_desc.last || !rtu;
					end
					frm_pkg::Q_CRC_LO:  b = crc_q[7:0];
					frm_pkg::Q_CRC_HI: begin
						b    = crc_q[15:8];
						done = 1'b1;
					end
					default:            b = 8'd0;
				endcase
			end
			frm_pkg::D_ERR_QTY: begin
				st   = frm_pkg::ST_QTY;
				done = 1'b1;
			end
			default: begin
				st   = frm_pkg::ST_ORPHAN;
				done = 1'b1;
			end
		endcase
	end

	// a header restarts the CRC on its first beat
	assign crc_base = (is_hdr && first_q) ? frm_pkg::CRC_INIT : crc_q;

	assign adv   = q_valid && (!out_valid_q || pop);
	assign q_pop = adv && done;
	assign empty = !out_valid_q;

	assign frame_byte    = byte_q;
	assign last_of_frame = last_q;
	assign status        = status_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			byte_q   <= b;
			last_q   <= done && (q_desc.dkind != frm_pkg::D_PAY || q_desc.last || !is_hdr)
				&& !(q_desc.dkind == frm_pkg::D_PAY && !q_desc.last)
				&& !(is_hdr && multi);
			status_q <= st;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			first_q     <= 1'b1;
			crc_q       <= frm_pkg::CRC_INIT;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= 1'b1;
				crc_q       <= feed ? frm_pkg::crc_byte(crc_base, b) : crc_base;
				first_q     <= done;
				pos_q       <= next_pos;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ test/fieldbus_request_framer_checker.sv @@
// Scoreboard for the fieldbus request framer: tracks config writes, predicts the
// RTU or TCP frame bytes of every accepted item and compares each popped beat.
// Depends on frm_pkg for kinds, limits, status codes and register indexes.
`timescale 1ns / 100ps

module fieldbus_request_framer_checker
	import frm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        push,
	input  logic        full,
	input  logic        action,
	input  logic [2:0]  request_kind,
	input  logic [15:0] start_address,
	input  logic [15:0] count_or_value,
	input  logic [15:0] payload_value,
	input  logic        empty,
	input  logic        pop,
	input  logic [7:0]  frame_byte,
	input  logic        last_of_frame,
	input  logic [1:0]  status,
	output int          mismatch_count,
	output int          beats_owed
);

	localparam logic [7:0] FC_READ_COILS   = 8'h01;
	localparam logic [7:0] FC_READ_INPUTS  = 8'h02;
	localparam logic [7:0] FC_READ_HOLDING = 8'h03;
	localparam logic [7:0] FC_WRITE_SINGLE = 8'h06;
	localparam logic [7:0] FC_WRITE_COILS  = 8'h0F;
	localparam logic [7:0] FC_WRITE_REGS   = 8'h10;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic [1:0] st;
	} frame_beat_t;

	frame_beat_t wire_bytes_due[$];
	frame_beat_t item_beats[$];

	logic [7:0]  unit_id;
	logic        tcp_mode;
	logic [15:0] txn_id;
	logic [15:0] crc_acc;
	logic [7:0]  words_left;
	logic [2:0]  open_kind;

	function automatic logic [15:0] crc16_fold(input logic [15:0] acc, input logic [7:0] b);
		logic [15:0] c;
		c = acc ^ {8'h00, b};
		repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		return c;
	endfunction

	task automatic put_beat(input logic [7:0] b, input logic feed);
		item_beats.push_back(frame_beat_t'{b, 1'b0, ST_OK});
		if (feed) crc_acc = crc16_fold(crc_acc, b);
	endtask

	task automatic put_word(input logic [15:0] w, input logic feed);
		put_beat(w[15:8], feed);
		put_beat(w[7:0], feed);
	endtask

	// RTU appends the CRC low byte first; either way flag the final byte
	task automatic close_frame();
		logic [15:0] c;
		c = crc_acc;
		if (!tcp_mode) begin
			put_beat(c[7:0], 1'b0);
			put_beat(c[15:8], 1'b0);
		end
		item_beats[item_beats.size() - 1].last = 1'b1;
	endtask

	task automatic frame_item(input logic act, input logic [2:0] kind,
			input logic [15:0] addr, input logic [15:0] cv, input logic [15:0] pv);
		logic rtu;
		logic ok;
		logic multi;
		logic [7:0] fcode;
		int nbytes;
		rtu = !tcp_mode;
		ok = 1'b0;
		fcode = 8'h00;
		item_beats.delete();
		if (words_left != 0) begin
			// pending write-multiple: the item is payload whatever its action bit
			if (open_kind == KIND_WR_COILS) begin
				put_beat(pv[7:0], rtu);
			end else begin
				put_word(pv, rtu);
			end
			words_left = words_left - 8'd1;
			if (words_left == 0) close_frame();
		end else if (act) begin
			item_beats.push_back(frame_beat_t'{8'h00, 1'b1, ST_ORPHAN});
		end else begin
			case (kind)
				KIND_RD_COILS: begin
					ok = cv >= 16'd1 && cv <= COIL_READ_MAX;
					fcode = FC_READ_COILS;
				end
				KIND_RD_INPUTS: begin
					ok = cv >= 16'd1 && cv <= COIL_READ_MAX;
					fcode = FC_READ_INPUTS;
				end
				KIND_RD_HOLD: begin
					ok = cv >= 16'd1 && cv <= HOLD_READ_MAX;
					fcode = FC_READ_HOLDING;
				end
				KIND_WR_SINGLE: begin
					ok = 1'b1;
					fcode = FC_WRITE_SINGLE;
				end
				KIND_WR_COILS: begin
					ok = cv >= 16'd1 && cv <= COIL_WRITE_MAX;
					fcode = FC_WRITE_COILS;
				end
				KIND_WR_REGS: begin
					ok = cv >= 16'd1 && cv <= REG_WRITE_MAX;
					fcode = FC_WRITE_REGS;
				end
				default: ok = 1'b0;
			endcase
			if (!ok) begin
				item_beats.push_back(frame_beat_t'{8'h00, 1'b1, ST_QTY});
			end else begin
				multi = kind == KIND_WR_COILS || kind == KIND_WR_REGS;
				if (kind == KIND_WR_COILS) nbytes = (int'(cv) + 7) / 8;
				else if (kind == KIND_WR_REGS) nbytes = 2 * int'(cv);
				else nbytes = 0;
				crc_acc = CRC_INIT;
				if (!rtu) begin
					txn_id = txn_id + 16'd1;
					put_word(txn_id, 1'b0);
					put_word(16'h0000, 1'b0);
					put_word(multi ? 16'(7 + nbytes) : 16'd6, 1'b0);
				end
				put_beat(unit_id, rtu);
				put_beat(fcode, rtu);
				put_word(addr, rtu);
				put_word(cv, rtu);
				if (multi) begin
					put_beat(8'(nbytes), rtu);
					words_left = (kind == KIND_WR_COILS) ? 8'(nbytes) : cv[7:0];
					open_kind = kind;
				end else begin
					close_frame();
				end
			end
		end
		foreach (item_beats[i]) wire_bytes_due.push_back(item_beats[i]);
	endtask

	task automatic check_wire_byte();
		frame_beat_t got;
		frame_beat_t want;
		got = frame_beat_t'{frame_byte, last_of_frame, status};
		if (wire_bytes_due.size() == 0) begin
			$display("%0t: expected no beat, got byte=%h last=%b status=%0d",
				$time, got.data, got.last, got.st);
			mismatch_count++;
		end else begin
			want = wire_bytes_due.pop_front();
			if (got.data !== want.data || got.last !== want.last || got.st !== want.st) begin
				$display("%0t: expected byte=%h last=%b status=%0d, got byte=%h last=%b status=%0d",
					$time, want.data, want.last, want.st, got.data, got.last, got.st);
				mismatch_count++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_id = 8'h00;
			tcp_mode = 1'b0;
			txn_id = 16'h0000;
			crc_acc = CRC_INIT;
			words_left = 8'h00;
			open_kind = KIND_RD_COILS;
			wire_bytes_due.delete();
			mismatch_count = 0;
			beats_owed <= 0;
		end else begin
			// the beat leaving now belongs to an earlier item, so check before predicting
			if (pop && !empty) check_wire_byte();
			if (cfg_we) begin
				if (cfg_index == CFG_UNIT_ID) unit_id = cfg_data;
				else tcp_mode = cfg_data[0];
			end
			if (push && !full)
				frame_item(action, request_kind, start_address, count_or_value, payload_value);
			beats_owed <= wire_bytes_due.size();
		end
	end

endmodule

@@ test/tb_fieldbus_request_framer_top.sv @@
// Testbench top for fieldbus_request_framer_top: clock, reset, config writes,
// directed and random request streams with idle/stall phases, and the verdict.
// Depends on frm_pkg, the framer RTL and fieldbus_request_framer_checker.
`timescale 1ns / 100ps

module tb_fieldbus_request_framer_top;
	import frm_pkg::*;

	localparam int QUIET_LIMIT = 4000;
	localparam int DRAIN_TAIL  = 20;
	localparam int PHASE_ITEMS = 62;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [7:0]  cfg_data;
	logic        push;
	logic        full;
	logic        action;
	logic [2:0]  request_kind;
	logic [15:0] start_address;
	logic [15:0] count_or_value;
	logic [15:0] payload_value;
	logic        empty;
	logic        pop;
	logic [7:0]  frame_byte;
	logic        last_of_frame;
	logic [1:0]  status;

	int mismatch_count;
	int beats_owed;
	int idle_pct;
	int stall_pct;
	int items_sent;
	int quiet_cycles = 0;

	fieldbus_request_framer_top dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.push(push), .full(full),
		.action(action), .request_kind(request_kind), .start_address(start_address),
		.count_or_value(count_or_value), .payload_value(payload_value),
		.empty(empty), .pop(pop),
		.frame_byte(frame_byte), .last_of_frame(last_of_frame), .status(status)
	);

	fieldbus_request_framer_checker scoreboard (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.push(push), .full(full),
		.action(action), .request_kind(request_kind), .start_address(start_address),
		.count_or_value(count_or_value), .payload_value(payload_value),
		.empty(empty), .pop(pop),
		.frame_byte(frame_byte), .last_of_frame(last_of_frame), .status(status),
		.mismatch_count(mismatch_count), .beats_owed(beats_owed)
	);

	always #1 clk = ~clk;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			pop <= $urandom_range(99) >= stall_pct;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	// hold the beat until the framer takes it
	task automatic send(input logic act, input logic [2:0] kind, input logic [15:0] addr,
			input logic [15:0] cv, input logic [15:0] pv);
		while ($urandom_range(99) < idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		action <= act;
		request_kind <= kind;
		start_address <= addr;
		count_or_value <= cv;
		payload_value <= pv;
		@(posedge clk);
		while (full) @(posedge clk);
		items_sent++;
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		@(posedge clk);
		while (beats_owed != 0) @(posedge clk);
	endtask

	task automatic write_config(input logic [7:0] unit_addr, input logic tcp);
		wait_drained();
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_UNIT_ID;
		cfg_data <= unit_addr;
		@(posedge clk);
		cfg_index <= CFG_TCP_MODE;
		cfg_data <= {7'($urandom), tcp};
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_payload();
		send($urandom_range(99) < 80, 3'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom));
	endtask

	function automatic logic [15:0] pick_quantity(input logic [2:0] kind);
		logic [15:0] q;
		case (kind)
			KIND_RD_COILS, KIND_RD_INPUTS:
				q = ($urandom_range(3) == 0) ? (($urandom_range(1)) ? COIL_READ_MAX : 16'd1)
					: 16'($urandom_range(1, COIL_READ_MAX));
			KIND_RD_HOLD:
				q = ($urandom_range(3) == 0) ? HOLD_READ_MAX : 16'($urandom_range(1, HOLD_READ_MAX));
			KIND_WR_COILS:
				q = ($urandom_range(99) < 2) ? 16'($urandom_range(1900, COIL_WRITE_MAX))
					: 16'($urandom_range(1, 40));
			KIND_WR_REGS:
				q = ($urandom_range(99) < 5) ? 16'($urandom_range(100, REG_WRITE_MAX))
					: 16'($urandom_range(1, 8));
			default: q = 16'($urandom);
		endcase
		return q;
	endfunction

	task automatic send_request();
		logic [2:0] kind;
		logic [15:0] cv;
		int owed;
		kind = 3'($urandom_range(KIND_WR_REGS));
		cv = pick_quantity(kind);
		send(1'b0, kind, 16'($urandom), cv, 16'($urandom));
		if (kind == KIND_WR_COILS) owed = (int'(cv) + 7) / 8;
		else if (kind == KIND_WR_REGS) owed = int'(cv);
		else owed = 0;
		repeat (owed) send_payload();
	endtask

	task automatic send_bad_request();
		logic [2:0] kind;
		logic [15:0] cap;
		int pick;
		do kind = 3'($urandom); while (kind == KIND_WR_SINGLE);
		case (kind)
			KIND_RD_COILS, KIND_RD_INPUTS: cap = COIL_READ_MAX;
			KIND_RD_HOLD:                  cap = HOLD_READ_MAX;
			KIND_WR_COILS:                 cap = COIL_WRITE_MAX;
			KIND_WR_REGS:                  cap = REG_WRITE_MAX;
			default:                       cap = 16'hFFFF;
		endcase
		pick = $urandom_range(2);
		send(1'b0, kind, 16'($urandom),
			(cap == 16'hFFFF) ? 16'($urandom) :
			(pick == 0) ? 16'd0 : (pick == 1) ? cap + 16'd1 : 16'($urandom_range(cap + 1, 16'hFFFF)),
			16'($urandom));
	endtask

	task automatic run_random(input int n_items);
		int stop_at;
		int roll;
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			roll = $urandom_range(99);
			if (roll < 72) send_request();
			else if (roll < 84) send_bad_request();
			else if (roll < 92) send(1'b1, 3'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
			else send($urandom_range(1), 3'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
			if ($urandom_range(99) < 3) wait_drained();
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_UNIT_ID;
		cfg_data = 8'h00;
		push = 1'b0;
		action = 1'b0;
		request_kind = KIND_RD_COILS;
		start_address = 16'h0000;
		count_or_value = 16'h0000;
		payload_value = 16'h0000;
		idle_pct = 0;
		stall_pct = 0;
		items_sent = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: RTU framing, limits, odd kinds, orphans, short write-multiples
		write_config(8'hA5, 1'b0);
		send(1'b0, KIND_RD_COILS, 16'h0000, 16'd1, 16'hFFFF);
		send(1'b0, KIND_RD_INPUTS, 16'hFFFF, COIL_READ_MAX, 16'h0000);
		send(1'b0, KIND_RD_HOLD, 16'h8001, HOLD_READ_MAX, 16'h5A5A);
		send(1'b0, KIND_RD_HOLD, 16'h0010, HOLD_READ_MAX + 16'd1, 16'h0000);
		send(1'b0, KIND_RD_COILS, 16'h0020, 16'd0, 16'h0000);
		send(1'b0, KIND_RD_INPUTS, 16'h0030, COIL_READ_MAX + 16'd1, 16'h0000);
		send(1'b0, KIND_WR_SINGLE, 16'h1234, 16'hFFFF, 16'h0000);
		send(1'b0, KIND_WR_SINGLE, 16'hFFFF, 16'h0000, 16'hFFFF);
		send(1'b0, 3'd6, 16'h0001, 16'd1, 16'h0000);
		send(1'b0, 3'd7, 16'h0001, 16'd1, 16'h0000);
		send(1'b1, KIND_RD_COILS, 16'h0000, 16'd1, 16'h00FF);
		send(1'b0, KIND_WR_COILS, 16'h0040, COIL_WRITE_MAX + 16'd1, 16'h0000);
		send(1'b0, KIND_WR_COILS, 16'h0041, 16'd0, 16'h0000);
		send(1'b0, KIND_WR_REGS, 16'h0042, REG_WRITE_MAX + 16'd1, 16'h0000);
		send(1'b0, KIND_WR_COILS, 16'h0100, 16'd9, 16'h0000);
		send(1'b1, KIND_RD_COILS, 16'h0000, 16'h0000, 16'hAB81);
		send(1'b0, KIND_RD_HOLD, 16'hFFFF, 16'hFFFF, 16'hFF7E);
		send(1'b0, KIND_WR_REGS, 16'h0200, 16'd2, 16'h0000);
		send(1'b1, KIND_WR_REGS, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send(1'b1, KIND_RD_COILS, 16'h0000, 16'h0000, 16'h0000);

		// directed: TCP framing, and a mode switch in the middle of a write-multiple
		write_config(8'hFF, 1'b1);
		send(1'b0, KIND_RD_HOLD, 16'h0300, 16'd1, 16'h0000);
		send(1'b0, KIND_WR_REGS, 16'h0301, 16'd2, 16'h0000);
		write_config(8'h00, 1'b0);
		send(1'b1, KIND_RD_COILS, 16'h0000, 16'h0000, 16'h1357);
		write_config(8'h00, 1'b1);
		send(1'b1, KIND_RD_COILS, 16'h0000, 16'h0000, 16'h2468);

		// random phases: free-running, sender idling, receiver stalling, both
		write_config(8'h00, 1'b0);
		run_random(PHASE_ITEMS);
		write_config(8'hFF, 1'b1);
		idle_pct = 82;
		run_random(PHASE_ITEMS);
		write_config(8'($urandom), 1'b0);
		idle_pct = 0;
		stall_pct = 82;
		run_random(PHASE_ITEMS);
		write_config(8'($urandom), 1'b1);
		idle_pct = 8;
		stall_pct = 8;
		run_random(PHASE_ITEMS);

		wait_drained();
		repeat (DRAIN_TAIL) @(posedge clk);
		if (mismatch_count == 0 && beats_owed == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
